>>> hdl/skos_pkg.sv
// Shared constants, name table and helpers for the key options scanner.
package skos_pkg;

	localparam int MAX_LEN = 4096;
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int NUM_NAMES = 17;
	localparam int NAME_MAX = 16;
	localparam int POS_W = 5;

	localparam logic [NUM_NAMES-1:0] ALL_NAMES = 17'h1FFFF;
	localparam logic [NUM_NAMES-1:0] NEG_NAMES = 17'h001FC;
	localparam logic [NUM_NAMES-1:0] ARG_NAMES = 17'h1FE00;

	// names are right-aligned in each vector; first character is the highest byte in use
	localparam logic [NAME_MAX*8-1:0] NAME_STR [NUM_NAMES] = '{
		"restrict", "cert-authority",
		"port-forwarding", "agent-forwarding", "x11-forwarding",
		"touch-required", "verify-required", "pty", "user-rc",
		"command", "principals", "from", "expiry-time",
		"environment", "permitopen", "permitlisten", "tunnel"
	};
	localparam logic [POS_W-1:0] NAME_LEN [NUM_NAMES] = '{
		5'd8, 5'd14, 5'd15, 5'd16, 5'd14, 5'd14, 5'd15, 5'd3, 5'd7,
		5'd7, 5'd10, 5'd4, 5'd11, 5'd11, 5'd10, 5'd12, 5'd6
	};

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_O  = 8'h6F;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_MALFORMED = 2'd1;
	localparam logic [1:0] STAT_TOO_LONG  = 2'd2;

	typedef struct packed {
		logic [NUM_NAMES-1:0] keep;
		logic                 hit;
		logic                 hit_arg;
	} match_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

endpackage

>>> hdl/skos_name_match.sv
// Parallel compare of one character against all option names.
module skos_name_match
	import skos_pkg::*;
(
	input  logic [7:0]           char_code,
	input  logic [NUM_NAMES-1:0] mask,
	input  logic [POS_W-1:0]     pos,
	output match_t               result
);

	logic [7:0]           lc;
	logic [NUM_NAMES-1:0] keep;
	logic [NUM_NAMES-1:0] done;
	logic [3:0]           bidx [NUM_NAMES];

	assign lc = fold(char_code);

	always_comb begin
		for (int i = 0; i < NUM_NAMES; i++) begin
			bidx[i] = 4'(NAME_LEN[i] - 5'd1 - pos);
			keep[i] = mask[i] && (pos < NAME_LEN[i]) &&
				(lc == NAME_STR[i][8*bidx[i] +: 8]);
			done[i] = keep[i] && (NAME_LEN[i] == pos + 5'd1);
		end
	end

	// lowest-index completed name decides the option kind
	always_comb begin
		result.keep = keep;
		result.hit = |done;
		result.hit_arg = 1'b0;
		for (int i = NUM_NAMES - 1; i >= 0; i--) begin
			if (done[i]) begin
				result.hit_arg = ARG_NAMES[i];
			end
		end
	end

endmodule

>>> hdl/ssh_key_options_scanner_core.sv
// Top level of the authorized-keys option list scanner.
// A word accepted into the input register is scanned from there once the output can
// take a result; any result it emits is registered onto m_tvalid by the result register.
// Throughput: one character per cycle; s_tready drops only while a result waits
// on the output with m_tready low.
// Reset (arst_n low): scanner idle until a word with start_of_line, output empty.
module ssh_key_options_scanner_core
	import skos_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic [0:0]  s_tuser,   // [0] start_of_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] options_length, [15:12] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_LINE_START = 4'd1;
	localparam logic [3:0] PH_AFTER_COMMA = 4'd2;
	localparam logic [3:0] PH_NEG1       = 4'd3;
	localparam logic [3:0] PH_NEG2       = 4'd4;
	localparam logic [3:0] PH_NAME       = 4'd5;
	localparam logic [3:0] PH_EQ         = 4'd6;
	localparam logic [3:0] PH_QUOTE      = 4'd7;
	localparam logic [3:0] PH_ARG        = 4'd8;
	localparam logic [3:0] PH_ARG_ESC    = 4'd9;
	localparam logic [3:0] PH_AFTER_OPT  = 4'd10;

	logic             valid_s1;
	logic             sol_s1;
	logic [7:0]       char_s1;

	logic [3:0]           phase_q;
	logic [NUM_NAMES-1:0] mask_q;
	logic [POS_W-1:0]     pos_q;
	logic                 neg_q;
	logic [CNT_W-1:0]     cnt_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [11:0] len_q;

	logic adv;
	logic accept;

	logic [3:0]           ph;
	logic [NUM_NAMES-1:0] mask_e;
	logic [POS_W-1:0]     pos_e;
	logic                 neg_e;
	logic [CNT_W-1:0]     cnt_e;
	logic [7:0]           lc;
	logic                 is_end;

	logic [NUM_NAMES-1:0] m_mask;
	logic [POS_W-1:0]     m_pos;
	match_t               mres;

	logic [3:0]           phase_n;
	logic [NUM_NAMES-1:0] mask_n;
	logic [POS_W-1:0]     pos_n;
	logic                 neg_n;
	logic [CNT_W-1:0]     cnt_n;
	logic                 emit;
	logic [1:0]           emit_status;
	logic [11:0]          emit_len;

	assign adv = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign accept = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sol_s1 <= s_tuser[0];
			char_s1 <= s_tdata;
		end
	end

	// start of line restarts everything
	assign ph     = sol_s1 ? PH_LINE_START : phase_q;
	assign mask_e = sol_s1 ? ALL_NAMES : mask_q;
	assign pos_e  = sol_s1 ? '0 : pos_q;
	assign neg_e  = sol_s1 ? 1'b0 : neg_q;
	assign cnt_e  = sol_s1 ? '0 : cnt_q;

	assign lc = fold(char_s1);
	assign is_end = (char_s1 == CH_NUL) || (char_s1 == CH_SPACE) || (char_s1 == CH_TAB);

	// a fresh option is matched from position zero against every name
	assign m_mask = (ph == PH_NAME) ? mask_e : ALL_NAMES;
	assign m_pos  = (ph == PH_NAME) ? pos_e : '0;

	skos_name_match u_match (
		.char_code (char_s1),
		.mask      (m_mask),
		.pos       (m_pos),
		.result    (mres)
	);

	always_comb begin
		phase_n = ph;
		mask_n = mask_e;
		pos_n = pos_e;
		neg_n = neg_e;
		cnt_n = cnt_e;
		emit = 1'b0;
		emit_status = STAT_OK;
		emit_len = '0;

		if (ph != PH_IDLE) begin
			if (cnt_e >= CNT_W'(MAX_LEN)) begin
				emit = 1'b1;
				emit_status = STAT_TOO_LONG;
			end else begin
				cnt_n = cnt_e + 1'b1;
				unique case (ph)
					PH_LINE_START, PH_AFTER_COMMA: begin
						if (ph == PH_AFTER_COMMA && char_s1 == CH_NUL) begin
							emit = 1'b1;
							emit_status = STAT_MALFORMED;
						end else if (is_end) begin
							emit = 1'b1;
							emit_len = 12'(cnt_e);
						end else if (char_s1 == CH_COMMA) begin
							phase_n = PH_AFTER_COMMA;
						end else begin
							mask_n = ALL_NAMES;
							pos_n = '0;
							neg_n = 1'b0;
							if (lc == CH_LOW_N) begin
								phase_n = PH_NEG1;
							end else begin
								mask_n = mres.keep;
								pos_n = m_pos + 1'b1;
								if (mres.keep == '0) begin
									emit = 1'b1;
									emit_status = STAT_MALFORMED;
								end else if (mres.hit) begin
									phase_n = mres.hit_arg ? PH_EQ : PH_AFTER_OPT;
								end else begin
									phase_n = PH_NAME;
								end
							end
						end
					end
					PH_NEG1: begin
						if (lc != CH_LOW_O) begin
							emit = 1'b1;
							emit_status = STAT_MALFORMED;
						end else begin
							phase_n = PH_NEG2;
						end
					end
					PH_NEG2: begin
						if (char_s1 != CH_DASH) begin
							emit = 1'b1;
							emit_status = STAT_MALFORMED;
						end else begin
							mask_n = NEG_NAMES;
							pos_n = '0;
							neg_n = 1'b1;
							phase_n = PH_NAME;
						end
					end
					PH_NAME: begin
						mask_n = mres.keep;
						pos_n = m_pos + 1'b1;
						if (mres.keep == '0) begin
							emit = 1'b1;
							emit_status = STAT_MALFORMED;
						end else if (mres.hit) begin
							phase_n = mres.hit_arg ? PH_EQ : PH_AFTER_OPT;
						end
					end
					PH_EQ: begin
						if (char_s1 != CH_EQUAL) begin
							emit = 1'b1;
							emit_status = STAT_MALFORMED;
						end else begin
							phase_n = PH_QUOTE;
						end
					end
					PH_QUOTE: begin
						if (char_s1 != CH_QUOTE) begin
							emit = 1'b1;
							emit_status = STAT_MALFORMED;
						end else begin
							phase_n = PH_ARG;
						end
					end
					PH_ARG, PH_ARG_ESC: begin
						if (char_s1 == CH_NUL) begin
							emit = 1'b1;
							emit_status = STAT_MALFORMED;
						end else if (char_s1 == CH_QUOTE) begin
							// escaped quote stays inside the argument
							phase_n = (ph == PH_ARG_ESC) ? PH_ARG : PH_AFTER_OPT;
						end else begin
							phase_n = (char_s1 == CH_BSLASH) ? PH_ARG_ESC : PH_ARG;
						end
					end
					PH_AFTER_OPT: begin
						if (is_end) begin
							emit = 1'b1;
							emit_len = 12'(cnt_e);
						end else if (char_s1 == CH_COMMA) begin
							phase_n = PH_AFTER_COMMA;
						end else begin
							emit = 1'b1;
							emit_status = STAT_MALFORMED;
						end
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
			if (emit) begin
				phase_n = PH_IDLE;
			end
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mask_q <= ALL_NAMES;
			pos_q <= '0;
			neg_q <= 1'b0;
			cnt_q <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			mask_q <= mask_n;
			pos_q <= pos_n;
			neg_q <= neg_n;
			cnt_q <= cnt_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			status_q <= emit_status;
			len_q <= emit_len;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'b0000, len_q};
	assign m_tuser = status_q;

endmodule
